/* hdl/uqoe_pkg.sv */
// Shared types, constants and character-class functions for the URL query option extractor.
`default_nettype none

package uqoe_pkg;

	// Fixed field and register widths.
	localparam int URL_BYTE_W  = 8;
	localparam int KEY_W       = 64;
	localparam int KEY_LEN_W   = 4;
	localparam int CAP_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int NAME_CNT_W  = 4;
	localparam int OUT_CNT_W   = 8;
	localparam int NIBBLE_W    = 4;
	localparam int STATUS_W    = 3;

	// Longest key the name comparator handles; key_chars holds this many bytes.
	localparam int MAX_KEY_LEN = 8;
	localparam int KEY_IDX_W   = $clog2(MAX_KEY_LEN);

	// Largest destination size the value length check honors.
	localparam int CAP_MAX     = 256;

	// Reset values of the configuration registers.
	localparam logic [KEY_W-1:0]     KEY_CHARS_RST = '0;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST   = '0;
	localparam logic [CAP_W-1:0]     CAP_RST       = CAP_W'(32);

	// Default depth of the queue between the parser and the output stage.
	localparam int QUEUE_DEPTH = 4;

	// Delimiters of the query syntax.
	localparam logic [URL_BYTE_W-1:0] CH_QUESTION = 8'h3F;
	localparam logic [URL_BYTE_W-1:0] CH_AMP      = 8'h26;
	localparam logic [URL_BYTE_W-1:0] CH_EQUAL    = 8'h3D;
	localparam logic [URL_BYTE_W-1:0] CH_PERCENT  = 8'h25;
	localparam logic [URL_BYTE_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [URL_BYTE_W-1:0] CH_DEL      = 8'h7F;

	// Result kinds.
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_NAME  = 3'd1,
		PH_SKIP  = 3'd2,
		PH_VALUE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND      = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_BAD_ESCAPE = 3'd2,
		ST_BAD_BYTE   = 3'd3,
		ST_UNSAFE     = 3'd4,
		ST_TOO_LONG   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_CHARS = 2'd0,
		CFG_KEY_LEN   = 2'd1,
		CFG_CAPACITY  = 2'd2
	} cfg_reg_t;

	// One queue entry: the results caused by one input byte.
	typedef struct packed {
		logic                  has_byte;
		logic [URL_BYTE_W-1:0] dbyte;
		logic                  has_status;
		status_t               code;
	} entry_t;

	// Hex digit decode: bit 4 set when the character is a hex digit.
	function automatic logic [NIBBLE_W:0] hex_decode(input logic [URL_BYTE_W-1:0] c);
		logic [NIBBLE_W:0] r;
		r = '0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, c[NIBBLE_W-1:0]};
			[8'h41:8'h46],
			[8'h61:8'h66]: r = {1'b1, NIBBLE_W'(c[2:0] + 3'd1) + NIBBLE_W'(8)};
			default:       r = '0;
		endcase
		return r;
	endfunction

	// Characters that may stand unescaped in a value.
	function automatic logic raw_allowed(input logic [URL_BYTE_W-1:0] c);
		logic ok;
		case (c) inside
			[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h2F, 8'h3A, 8'h40,
			8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
			8'h2B, 8'h2C, 8'h3B, 8'h3D: ok = 1'b1;
			default:                    ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

/* hdl/uqoe_front.sv */
// Front part: configuration registers and the per-byte query parser.
`default_nettype none

module uqoe_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_accept,
	input  wire logic [uqoe_pkg::URL_BYTE_W-1:0]    url_byte,
	input  wire logic                               in_last,
	input  wire logic                               cfg_write,
	input  wire logic [uqoe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [uqoe_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                    entry_valid,
	output uqoe_pkg::entry_t                        entry
);
	import uqoe_pkg::*;

	logic [KEY_W-1:0]      key_chars_q;
	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [CAP_W-1:0]      value_capacity_q;

	phase_t                phase_q, phase_n;
	logic [NAME_CNT_W-1:0] name_count_q, name_count_n;
	logic                  name_mismatch_q, name_mismatch_n;
	esc_t                  escape_step_q, escape_step_n;
	logic [NIBBLE_W-1:0]   high_nibble_q, high_nibble_n;
	logic [OUT_CNT_W-1:0]  out_count_q, out_count_n;
	status_t               result_code_q, result_code_n;

	logic                  emit;
	logic [URL_BYTE_W-1:0] emit_val;
	status_t               final_code;

	logic [NIBBLE_W:0]     hex;
	logic [URL_BYTE_W-1:0] key_byte;
	logic [URL_BYTE_W-1:0] decoded;
	logic                  name_in_key;
	logic                  key_match;
	logic [CAP_W-1:0]      cap_eff;
	logic                  room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q      <= KEY_CHARS_RST;
			key_length_q     <= KEY_LEN_RST;
			value_capacity_q <= CAP_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KEY_CHARS: key_chars_q      <= cfg_data;
				CFG_KEY_LEN:   key_length_q     <= cfg_data[KEY_LEN_W-1:0];
				CFG_CAPACITY:  value_capacity_q <= cfg_data[CAP_W-1:0];
				default:       ;
			endcase
		end
	end

	assign hex         = hex_decode(url_byte);
	assign key_byte    = key_chars_q[{name_count_q[KEY_IDX_W-1:0], 3'b000} +: URL_BYTE_W];
	assign decoded     = {high_nibble_q, hex[NIBBLE_W-1:0]};
	assign name_in_key = (name_count_q < key_length_q)
	                     && (name_count_q < NAME_CNT_W'(MAX_KEY_LEN));
	assign key_match   = !name_mismatch_q && (key_length_q <= KEY_LEN_W'(MAX_KEY_LEN))
	                     && (name_count_q == key_length_q);
	assign cap_eff     = (value_capacity_q > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX)
	                                                          : value_capacity_q;
	assign room        = (({1'b0, out_count_q} + CAP_W'(1)) < cap_eff);

	// Next-state logic for one accepted byte.
	always_comb begin
		phase_n         = phase_q;
		name_count_n    = name_count_q;
		name_mismatch_n = name_mismatch_q;
		escape_step_n   = escape_step_q;
		high_nibble_n   = high_nibble_q;
		out_count_n     = out_count_q;
		result_code_n   = result_code_q;
		emit            = 1'b0;
		emit_val        = url_byte;

		unique case (phase_q)
			PH_WAIT: begin
				if (url_byte == CH_QUESTION) begin
					phase_n         = PH_NAME;
					name_count_n    = '0;
					name_mismatch_n = 1'b0;
				end
			end
			PH_NAME: begin
				if (url_byte == CH_AMP) begin
					name_count_n    = '0;
					name_mismatch_n = 1'b0;
				end else if (url_byte == CH_EQUAL) begin
					if (key_match) begin
						if (value_capacity_q == '0) begin
							phase_n       = PH_DONE;
							result_code_n = ST_NOT_FOUND;
						end else begin
							phase_n       = PH_VALUE;
							escape_step_n = ESC_NONE;
							out_count_n   = '0;
						end
					end else begin
						phase_n = PH_SKIP;
					end
				end else begin
					if (!name_in_key || (key_byte != url_byte)) begin
						name_mismatch_n = 1'b1;
					end
					if (name_count_q != '1) begin
						name_count_n = name_count_q + NAME_CNT_W'(1);
					end
				end
			end
			PH_SKIP: begin
				if (url_byte == CH_AMP) begin
					phase_n         = PH_NAME;
					name_count_n    = '0;
					name_mismatch_n = 1'b0;
				end
			end
			PH_VALUE: begin
				if (escape_step_q == ESC_HIGH) begin
					if (!hex[NIBBLE_W]) begin
						phase_n       = PH_DONE;
						result_code_n = ST_BAD_ESCAPE;
					end else begin
						high_nibble_n = hex[NIBBLE_W-1:0];
						escape_step_n = ESC_LOW;
					end
				end else if (escape_step_q == ESC_LOW) begin
					if (!hex[NIBBLE_W]) begin
						phase_n       = PH_DONE;
						result_code_n = ST_BAD_ESCAPE;
					end else begin
						escape_step_n = ESC_NONE;
						emit_val      = decoded;
						if ((decoded < CH_SPACE) || (decoded == CH_DEL)) begin
							phase_n       = PH_DONE;
							result_code_n = ST_BAD_BYTE;
						end else if (room) begin
							emit        = 1'b1;
							out_count_n = out_count_q + OUT_CNT_W'(1);
						end else begin
							phase_n       = PH_DONE;
							result_code_n = ST_TOO_LONG;
						end
					end
				end else if (url_byte == CH_AMP) begin
					phase_n       = PH_DONE;
					result_code_n = ST_FOUND;
				end else if (url_byte == CH_PERCENT) begin
					escape_step_n = ESC_HIGH;
				end else if (!raw_allowed(url_byte)) begin
					phase_n       = PH_DONE;
					result_code_n = ST_UNSAFE;
				end else if (room) begin
					emit        = 1'b1;
					out_count_n = out_count_q + OUT_CNT_W'(1);
				end else begin
					phase_n       = PH_DONE;
					result_code_n = ST_TOO_LONG;
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	// Result entry for the accepted byte; the status reflects the state after it.
	always_comb begin
		if (phase_n == PH_VALUE) begin
			final_code = (escape_step_n != ESC_NONE) ? ST_BAD_ESCAPE : ST_FOUND;
		end else if (phase_n == PH_DONE) begin
			final_code = result_code_n;
		end else begin
			final_code = ST_NOT_FOUND;
		end
		entry_valid      = in_accept && (emit || in_last);
		entry.has_byte   = emit;
		entry.dbyte      = emit_val;
		entry.has_status = in_last;
		entry.code       = final_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_WAIT;
			name_count_q    <= '0;
			name_mismatch_q <= 1'b0;
			escape_step_q   <= ESC_NONE;
			high_nibble_q   <= '0;
			out_count_q     <= '0;
			result_code_q   <= ST_NOT_FOUND;
		end else if (in_accept) begin
			if (in_last) begin
				phase_q         <= PH_WAIT;
				name_count_q    <= '0;
				name_mismatch_q <= 1'b0;
				escape_step_q   <= ESC_NONE;
				high_nibble_q   <= '0;
				out_count_q     <= '0;
				result_code_q   <= ST_NOT_FOUND;
			end else begin
				phase_q         <= phase_n;
				name_count_q    <= name_count_n;
				name_mismatch_q <= name_mismatch_n;
				escape_step_q   <= escape_step_n;
				high_nibble_q   <= high_nibble_n;
				out_count_q     <= out_count_n;
				result_code_q   <= result_code_n;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/uqoe_queue.sv */
// Short queue of result entries between the parser and the output stage.
`default_nettype none

module uqoe_queue #(
	parameter int DEPTH = uqoe_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire uqoe_pkg::entry_t wr_entry,
	output logic                  full,
	input  wire logic             rd_en,
	output logic                  head_valid,
	output uqoe_pkg::entry_t      head
);
	import uqoe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/uqoe_back.sv */
// Back part: splits queue entries into single results and holds them in an output register.
`default_nettype none

module uqoe_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             head_valid,
	input  wire uqoe_pkg::entry_t                 head,
	output logic                                  head_pop,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  out_kind,
	output logic [uqoe_pkg::URL_BYTE_W-1:0]       out_byte,
	output logic [uqoe_pkg::STATUS_W-1:0]         status,
	output logic                                  out_last
);
	import uqoe_pkg::*;

	logic                  out_valid_q;
	logic                  byte_sent_q;
	logic                  out_kind_q;
	logic [URL_BYTE_W-1:0] out_byte_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  load;
	logic                  take_byte;

	assign load      = head_valid && (!out_valid_q || pop);
	assign take_byte = head.has_byte && !byte_sent_q;
	// The head leaves the queue once its last result has been loaded.
	assign head_pop  = load && !(take_byte && head.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_sent_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				byte_sent_q <= take_byte && head.has_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (take_byte) begin
				out_kind_q <= KIND_BYTE;
				out_byte_q <= head.dbyte;
				status_q   <= ST_FOUND;
			end else begin
				out_kind_q <= KIND_STATUS;
				out_byte_q <= '0;
				status_q   <= head.code;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_kind = out_kind_q;
	assign out_byte = out_byte_q;
	assign status   = status_q;
	assign out_last = (out_kind_q == KIND_STATUS);

endmodule

`default_nettype wire

/* hdl/url_query_option_extract_top.sv */
// Top level of the URL query option extractor.
`default_nettype none

// The block reads a URL one byte per transfer on the push side and returns the
// percent-decoded value of the query option whose name matches key_chars and
// key_length, one decoded byte per result transfer, followed by one status
// result (out_kind high, out_last high) for the byte marked in_last. Status is
// 0 found, 1 not found, 2 bad escape, 3 escaped control byte, 4 unsafe raw
// character, 5 value too long for value_capacity; only the first error counts.
// A byte is taken while push is high and the queue is not full, so a new byte
// can follow every clock while the queue has room; the parser updates its
// state with each accepted byte. Results pass through a queue of QUEUE_DEPTH
// entries and a one-result output register, so the push side keeps running
// while results wait to be popped, until the queue fills. A byte that causes
// both a decoded byte and the final status needs two pop transfers, so the
// result side sets the long-run rate when such bytes arrive back to back.
// The configuration registers are written through cfg_write, cfg_index and
// cfg_data (0 key_chars, 1 key_length, 2 value_capacity); the user must write
// them only while the block holds no pending results; the block does not check.
module url_query_option_extract_top #(
	parameter int QUEUE_DEPTH = uqoe_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [uqoe_pkg::URL_BYTE_W-1:0]  url_byte,
	input  wire logic                             in_last,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  out_kind,
	output logic [uqoe_pkg::URL_BYTE_W-1:0]       out_byte,
	output logic [uqoe_pkg::STATUS_W-1:0]         status,
	output logic                                  out_last,
	input  wire logic                             cfg_write,
	input  wire logic [uqoe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [uqoe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import uqoe_pkg::*;

	logic   in_accept;
	logic   entry_valid;
	entry_t entry;
	logic   head_valid;
	entry_t head;
	logic   head_pop;

	// A byte transfers whenever the queue has room for what it may produce.
	assign in_accept = push && !full;

	uqoe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.url_byte    (url_byte),
		.in_last     (in_last),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.entry_valid (entry_valid),
		.entry       (entry)
	);

	uqoe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (entry_valid),
		.wr_entry   (entry),
		.full       (full),
		.rd_en      (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	uqoe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.status     (status),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire
